// ----- rtl/core/rcslf_pkg.sv -----
// ----------------------------------------------------------------------------
// RC channel signal loss filter package
// Shared constants, configuration register indexes and status types.
// ----------------------------------------------------------------------------
package rcslf_pkg;

    // Channel layout: four lanes, lane three carries the throttle.
    localparam int NUM_CH = 4;
    localparam int THR_CH = 3;

    // Time and hold time field widths.
    localparam int TIME_W = 32;
    localparam int HOLD_W = 16;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_VALUE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FS_ENABLED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUIRED     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME    = 3'd6;

    // Reset values of the configuration registers and channel state.
    localparam logic [15:0]       MIN_PULSE_RST = 16'd885;
    localparam logic [15:0]       MAX_PULSE_RST = 16'd2115;
    localparam logic [15:0]       MID_VALUE_RST = 16'd1500;
    localparam logic [2:0]        ACTIVE_RST    = 3'd4;
    localparam logic [NUM_CH-1:0] REQUIRED_RST  = 4'hF;
    localparam logic [HOLD_W-1:0] HOLD_TIME_RST = 16'd300;
    localparam logic [TIME_W-1:0] DEADLINE_RST  = 32'd300;

    // Output status bit positions in the result tuser.
    localparam int USER_VALID = 0;
    localparam int USER_LINK  = 1;

    // Frame-level link decision.
    typedef struct packed {
        logic channels_valid;
        logic link_up;
    } link_status_t;

endpackage

// ----- rtl/core/rc_channel_signal_loss_filter.sv -----
// ----------------------------------------------------------------------------
// RC channel signal loss filter
// Four lanes check pulse windows and deadlines and average each channel;
// a merge stage decides the link status; a two-entry queue holds results.
// ----------------------------------------------------------------------------
// A result is valid in the cycle after its frame is accepted.
// Throughput: one frame per cycle unless the queue is full; all channel state updates in the accept cycle.
// Input stalls only when both output queue entries are full.
// Reset: configuration, held values, deadlines and history return to defaults
// at once; no clearing pass.
module rc_channel_signal_loss_filter #(
    parameter int AVG_DEPTH  = 3,
    parameter int PULSE_BITS = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Frame input
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // pulse_0, pulse_1, pulse_2, pulse_3, now_ms, zero fill
    input  logic [((4*PULSE_BITS+32+7)/8)*8-1:0] s_tdata,
    // failsafe_switch
    input  logic [0:0]                           s_tuser,
    // Result output
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // value_0, value_1, value_2, value_3, zero fill
    output logic [((4*PULSE_BITS+7)/8)*8-1:0]    m_tdata,
    // channels_valid, link_up
    output logic [1:0]                           m_tuser,
    // Configuration write
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rcslf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rcslf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int NUM_CH  = rcslf_pkg::NUM_CH;
    localparam int SLOT_W  = $clog2(AVG_DEPTH);
    localparam int VALS_W  = NUM_CH * PULSE_BITS;
    localparam int OUT_W   = ((4*PULSE_BITS+7)/8)*8;
    localparam int ENTRY_W = OUT_W + 2;
    localparam int TIME_LO = NUM_CH * PULSE_BITS;

    // Configuration registers.
    logic [PULSE_BITS-1:0]        min_pulse_reg;
    logic [PULSE_BITS-1:0]        max_pulse_reg;
    logic [PULSE_BITS-1:0]        mid_value_reg;
    logic                         fs_enabled_reg;
    logic [2:0]                   active_ch_reg;
    logic [NUM_CH-1:0]            required_reg;
    logic [rcslf_pkg::HOLD_W-1:0] hold_time_reg;

    // Frame sequencing state.
    logic [SLOT_W-1:0]            hist_slot_reg;
    logic [SLOT_W-1:0]            hist_slot_next;
    logic                         hist_filled_reg;
    logic                         hist_filled_next;

    logic                         accept;
    logic                         cfg_write;
    logic [rcslf_pkg::TIME_W-1:0] now_ms;
    logic [NUM_CH-1:0]            fail_vec;
    logic [VALS_W-1:0]            values;
    rcslf_pkg::link_status_t      status;
    logic [ENTRY_W-1:0]           push_data;
    logic [ENTRY_W-1:0]           out_data;
    logic                         q_ready;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = q_ready;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign now_ms    = s_tdata[TIME_LO +: rcslf_pkg::TIME_W];

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pulse_reg  <= rcslf_pkg::MIN_PULSE_RST[PULSE_BITS-1:0];
            max_pulse_reg  <= rcslf_pkg::MAX_PULSE_RST[PULSE_BITS-1:0];
            mid_value_reg  <= rcslf_pkg::MID_VALUE_RST[PULSE_BITS-1:0];
            fs_enabled_reg <= 1'b0;
            active_ch_reg  <= rcslf_pkg::ACTIVE_RST;
            required_reg   <= rcslf_pkg::REQUIRED_RST;
            hold_time_reg  <= rcslf_pkg::HOLD_TIME_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rcslf_pkg::CFG_MIN_PULSE:  min_pulse_reg  <= cfg_data[PULSE_BITS-1:0];
                rcslf_pkg::CFG_MAX_PULSE:  max_pulse_reg  <= cfg_data[PULSE_BITS-1:0];
                rcslf_pkg::CFG_MID_VALUE:  mid_value_reg  <= cfg_data[PULSE_BITS-1:0];
                rcslf_pkg::CFG_FS_ENABLED: fs_enabled_reg <= cfg_data[0];
                rcslf_pkg::CFG_ACTIVE_CH:  active_ch_reg  <= cfg_data[2:0];
                rcslf_pkg::CFG_REQUIRED:   required_reg   <= cfg_data[NUM_CH-1:0];
                rcslf_pkg::CFG_HOLD_TIME:  hold_time_reg  <= cfg_data[rcslf_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // History slot advances every frame and marks the history full on wrap.
    always_comb
    begin
        hist_filled_next = hist_filled_reg;
        if (hist_slot_reg == SLOT_W'(AVG_DEPTH - 1))
        begin
            hist_slot_next   = '0;
            hist_filled_next = 1'b1;
        end
        else
        begin
            hist_slot_next = hist_slot_reg + SLOT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_slot_reg   <= '0;
            hist_filled_reg <= 1'b0;
        end
        else if (accept)
        begin
            hist_slot_reg   <= hist_slot_next;
            hist_filled_reg <= hist_filled_next;
        end
    end

    // Channel lanes.
    for (genvar i = 0; i < NUM_CH; i++)
    begin : g_lane
        localparam bit IS_THR = (i == rcslf_pkg::THR_CH);

        logic lane_active;

        // Counts above four enable all lanes.
        assign lane_active = (active_ch_reg > 3'(i));

        rcslf_lane #(
            .PULSE_BITS (PULSE_BITS),
            .AVG_DEPTH  (AVG_DEPTH),
            .THROTTLE   (IS_THR)
        ) u_lane (
            .clk          (clk),
            .rst_n        (rst_n),
            .step         (accept),
            .active       (lane_active),
            .pulse        (s_tdata[i*PULSE_BITS +: PULSE_BITS]),
            .now_ms       (now_ms),
            .min_pulse    (min_pulse_reg),
            .max_pulse    (max_pulse_reg),
            .fail_value   (IS_THR ? min_pulse_reg : mid_value_reg),
            .hold_time_ms (hold_time_reg),
            .hist_slot    (hist_slot_reg),
            .hist_filled  (hist_filled_reg),
            .link_down    (!status.link_up),
            .value        (values[i*PULSE_BITS +: PULSE_BITS]),
            .fail         (fail_vec[i])
        );
    end

    // Link decision over all lanes.
    rcslf_merge u_merge (
        .fail_vec         (fail_vec),
        .required_mask    (required_reg),
        .failsafe_switch  (s_tuser[0]),
        .failsafe_enabled (fs_enabled_reg),
        .status           (status)
    );

    // Result assembly and queue.
    assign push_data = {status.link_up, status.channels_valid, OUT_W'(values)};

    rcslf_outq #(
        .W (ENTRY_W)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (push_data),
        .ready     (q_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = out_data[OUT_W-1:0];
    assign m_tuser = out_data[ENTRY_W-1:OUT_W];

    // An accepted frame always leaves a result pending next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted frame produced no pending result");

    // Link up is never reported with an invalid required channel.
    a_link_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tuser[rcslf_pkg::USER_LINK] || m_tuser[rcslf_pkg::USER_VALID]))
        else $error("link up reported while channels invalid");

    // The history slot stays within the averaging depth.
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        hist_slot_reg <= SLOT_W'(AVG_DEPTH - 1))
        else $error("history slot out of range");

    // History becomes full exactly when the slot wraps on a frame.
    a_filled_on_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !hist_filled_reg && hist_slot_reg == SLOT_W'(AVG_DEPTH - 1))
        |=> hist_filled_reg)
        else $error("history not marked full after wrap");

endmodule

// ----- rtl/core/rcslf_lane.sv -----
// ----------------------------------------------------------------------------
// RC channel signal loss filter lane
// One channel: window check, hold deadline, failsafe substitution and the
// moving average over the last frames. Holds the channel's own state.
// ----------------------------------------------------------------------------
module rcslf_lane #(
    parameter int PULSE_BITS = 12,
    parameter int AVG_DEPTH  = 3,
    parameter bit THROTTLE   = 1'b0
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic                            active,
    input  logic [PULSE_BITS-1:0]           pulse,
    input  logic [rcslf_pkg::TIME_W-1:0]    now_ms,
    input  logic [PULSE_BITS-1:0]           min_pulse,
    input  logic [PULSE_BITS-1:0]           max_pulse,
    input  logic [PULSE_BITS-1:0]           fail_value,
    input  logic [rcslf_pkg::HOLD_W-1:0]    hold_time_ms,
    input  logic [$clog2(AVG_DEPTH)-1:0]    hist_slot,
    input  logic                            hist_filled,
    input  logic                            link_down,
    output logic [PULSE_BITS-1:0]           value,
    output logic                            fail
);

    localparam int SLOT_W = $clog2(AVG_DEPTH);
    localparam int SUM_W  = PULSE_BITS + SLOT_W;
    // Reciprocal for floor division of a SUM_W-bit sum by AVG_DEPTH.
    localparam int              SHIFT   = SUM_W + SLOT_W;
    localparam longint unsigned RECIP_L = ((64'd1 << SHIFT) / AVG_DEPTH) + 64'd1;
    localparam logic [SUM_W:0]  RECIP   = RECIP_L[SUM_W:0];
    localparam int              PROD_W  = 2 * SUM_W + 1;

    localparam logic [PULSE_BITS-1:0] HELD_RST = THROTTLE ?
        rcslf_pkg::MIN_PULSE_RST[PULSE_BITS-1:0] :
        rcslf_pkg::MID_VALUE_RST[PULSE_BITS-1:0];

    logic [PULSE_BITS-1:0]        held_reg;
    logic [PULSE_BITS-1:0]        held_next;
    logic [rcslf_pkg::TIME_W-1:0] deadline_reg;
    logic [rcslf_pkg::TIME_W-1:0] deadline_next;
    logic [PULSE_BITS-1:0]        hist_reg [AVG_DEPTH];

    logic                         in_window;
    logic                         before_deadline;
    logic [rcslf_pkg::TIME_W:0]   dl_sum;
    logic [PULSE_BITS-1:0]        sample;
    logic [SUM_W-1:0]             sum;
    logic [PROD_W-1:0]            prod;
    logic [PULSE_BITS-1:0]        avg;
    logic                         commit;

    assign commit = step && active;

    // Window check and deadline compare against the stored deadline.
    assign in_window       = (pulse >= min_pulse) && (pulse <= max_pulse);
    assign before_deadline = now_ms < deadline_reg;
    assign fail            = active && !in_window && !before_deadline;

    // Renewed deadline saturates instead of wrapping.
    assign dl_sum        = {1'b0, now_ms} + (rcslf_pkg::TIME_W + 1)'(hold_time_ms);
    assign deadline_next = dl_sum[rcslf_pkg::TIME_W] ? '1 : dl_sum[rcslf_pkg::TIME_W-1:0];

    // Sample entering the average: fresh pulse, held value or failsafe value.
    always_comb
    begin
        if (in_window)
            sample = pulse;
        else if (before_deadline)
            sample = held_reg;
        else
            sample = fail_value;
    end

    // Sum of the history with the current slot replaced by the new sample.
    always_comb
    begin
        sum = '0;
        for (int k = 0; k < AVG_DEPTH; k++)
        begin
            if (SLOT_W'(k) == hist_slot)
                sum = sum + SUM_W'(sample);
            else
                sum = sum + SUM_W'(hist_reg[k]);
        end
    end

    // Division by the averaging depth as a reciprocal multiplication.
    assign prod = PROD_W'(sum) * PROD_W'(RECIP);
    assign avg  = hist_filled ? prod[SHIFT +: PULSE_BITS] : sample;

    // Link down forces the failsafe value into the held register.
    always_comb
    begin
        if (!active)
            held_next = held_reg;
        else if (link_down)
            held_next = fail_value;
        else
            held_next = avg;
    end

    assign value = held_next;

    // Held value and deadline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg     <= HELD_RST;
            deadline_reg <= rcslf_pkg::DEADLINE_RST;
        end
        else if (commit)
        begin
            held_reg <= held_next;
            if (in_window)
                deadline_reg <= deadline_next;
        end
    end

    // Sample history, one slot written per frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < AVG_DEPTH; k++)
                hist_reg[k] <= '0;
        end
        else if (commit)
        begin
            for (int k = 0; k < AVG_DEPTH; k++)
            begin
                if (SLOT_W'(k) == hist_slot)
                    hist_reg[k] <= sample;
            end
        end
    end

endmodule

// ----- rtl/core/rcslf_merge.sv -----
// ----------------------------------------------------------------------------
// RC channel signal loss filter merge
// Combines the lane failure flags into the frame's valid and link status.
// ----------------------------------------------------------------------------
module rcslf_merge (
    input  logic [rcslf_pkg::NUM_CH-1:0] fail_vec,
    input  logic [rcslf_pkg::NUM_CH-1:0] required_mask,
    input  logic                         failsafe_switch,
    input  logic                         failsafe_enabled,
    output rcslf_pkg::link_status_t      status
);

    // A failed channel matters only when it is required.
    always_comb
    begin
        status.channels_valid = ((fail_vec & required_mask) == '0);
        status.link_up        = status.channels_valid &&
                                !(failsafe_switch && failsafe_enabled);
    end

endmodule

// ----- rtl/core/rcslf_outq.sv -----
// ----------------------------------------------------------------------------
// RC channel signal loss filter output queue
// Two-entry result buffer that decouples the input side from output stalls.
// ----------------------------------------------------------------------------
module rcslf_outq #(
    parameter int W = 50
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         ready,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    logic [W-1:0] entry_reg [2];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic         pop;

    assign ready     = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- tb/sv/rc_channel_signal_loss_filter_tb.sv -----
// ----------------------------------------------------------------------------
// RC channel signal loss filter testbench
// Sends frames of four pulse widths, a millisecond time stamp and the failsafe
// switch through the stream input, and checks every result against a local
// model of the window check, hold deadlines, three-frame averaging and link
// decision. A short directed list comes first, then randomized phases that
// each start with a fresh register setting. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module rc_channel_signal_loss_filter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CH      = rcslf_pkg::NUM_CH;
    localparam int THR_CH      = rcslf_pkg::THR_CH;
    localparam int IDX_W       = rcslf_pkg::CFG_IDX_W;
    localparam int DATA_W      = rcslf_pkg::CFG_DATA_W;
    localparam int PB          = 12;
    localparam int AVG         = 3;
    localparam int SD_W        = ((4*PB+32+7)/8)*8;
    localparam int MD_W        = ((4*PB+7)/8)*8;
    localparam int CYCLE_LIMIT = 400000;

    // One frame as it travels on the input stream.
    typedef struct packed {
        logic                     sw;
        logic [31:0]              now;
        logic [NUM_CH-1:0][PB-1:0] pulse;
    } frame_t;

    // One result as it leaves the block.
    typedef struct packed {
        logic                     link;
        logic                     valid;
        logic [NUM_CH-1:0][PB-1:0] vals;
    } result_t;

    typedef enum logic {ROW_CFG, ROW_FRAME} row_kind_t;

    // One line of the directed list: a register write or a frame.
    typedef struct packed {
        row_kind_t          kind;
        logic [IDX_W-1:0]   idx;
        logic [DATA_W-1:0]  data;
        frame_t             frm;
        logic               typed;
        result_t            res;
    } row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [SD_W-1:0]      s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [MD_W-1:0]      m_tdata;
    logic [1:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [IDX_W-1:0]     cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data = '0;

    // Shadow registers and channel state of the local model.
    logic [PB-1:0]             min_p, max_p, mid_v;
    logic                      fs_en;
    logic [2:0]                act_ch;
    logic [NUM_CH-1:0]         req_mask;
    logic [15:0]               hold_ms;
    logic [NUM_CH-1:0][PB-1:0] held;
    logic [PB-1:0]             history [NUM_CH][AVG];
    logic [31:0]               deadline [NUM_CH];
    int                        slot;
    logic                      hist_full;

    result_t pending_results[$];
    row_t    stim_rows[$];
    logic    no_idle = 1'b0;
    int      err_cnt = 0;
    int      cycle_cnt = 0;
    int      frames_sent = 0;
    int      cfg_writes = 0;
    int      results_checked = 0;
    int      link_downs = 0;
    int      hold_hits = 0;
    int      fs_hits = 0;

    rc_channel_signal_loss_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("rc_channel_signal_loss_filter test failed");
            $finish;
        end
    end

    // Failsafe value of a channel: throttle drops to the minimum pulse.
    function automatic logic [PB-1:0] failsafe_of(int ch);
        return (ch == THR_CH) ? min_p : mid_v;
    endfunction

    // Applies one frame to the model state and returns the filtered result.
    function automatic result_t filter_frame(frame_t f);
        result_t           r;
        logic [PB-1:0]     v;
        logic [32:0]       renew;
        logic [NUM_CH-1:0] ok_mask;
        int                n;
        int                ch;
        int                k;
        int                sum;
        n = (act_ch > 3'd4) ? NUM_CH : int'(act_ch);
        ok_mask = req_mask;
        for (ch = 0; ch < n; ch++)
        begin
            v = f.pulse[ch];
            if (v >= min_p && v <= max_p)
            begin
                // Good pulse: push the deadline out, saturating at the top.
                renew = {1'b0, f.now} + {17'd0, hold_ms};
                deadline[ch] = renew[32] ? 32'hFFFF_FFFF : renew[31:0];
            end
            else if (f.now < deadline[ch])
            begin
                v = held[ch];
                hold_hits++;
            end
            else
            begin
                v = failsafe_of(ch);
                ok_mask[ch] = 1'b0;
                fs_hits++;
            end
            history[ch][slot] = v;
            if (hist_full)
            begin
                sum = 0;
                for (k = 0; k < AVG; k++)
                    sum += int'(history[ch][k]);
                held[ch] = PB'(sum / AVG);
            end
            else
                held[ch] = v;
        end
        r.valid = (ok_mask == req_mask);
        r.link  = r.valid && !(f.sw && fs_en);
        if (!r.link)
        begin
            link_downs++;
            for (ch = 0; ch < n; ch++)
                held[ch] = failsafe_of(ch);
        end
        slot++;
        if (slot >= AVG)
        begin
            slot = 0;
            hist_full = 1'b1;
        end
        r.vals = held;
        return r;
    endfunction

    // Writes one register once the block has drained, then updates the shadow.
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            rcslf_pkg::CFG_MIN_PULSE:  min_p    = data[PB-1:0];
            rcslf_pkg::CFG_MAX_PULSE:  max_p    = data[PB-1:0];
            rcslf_pkg::CFG_MID_VALUE:  mid_v    = data[PB-1:0];
            rcslf_pkg::CFG_FS_ENABLED: fs_en    = data[0];
            rcslf_pkg::CFG_ACTIVE_CH:  act_ch   = data[2:0];
            rcslf_pkg::CFG_REQUIRED:   req_mask = data[NUM_CH-1:0];
            rcslf_pkg::CFG_HOLD_TIME:  hold_ms  = data[15:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Offers one frame after a random gap and records its expected result.
    task automatic send_frame(frame_t f, logic typed, result_t typed_res);
        int      gap;
        result_t pred;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {f.now, f.pulse};
        s_tuser  <= f.sw;
        do @(posedge clk); while (!s_tready);
        pred = filter_frame(f);
        pending_results.push_back(typed ? typed_res : pred);
        frames_sent++;
    endtask

    // Builders for the directed list.
    function automatic void add_frame(int p0, int p1, int p2, int p3,
                                      logic [31:0] t, logic sw);
        row_t row;
        row = '0;
        row.kind = ROW_FRAME;
        row.frm.pulse[0] = PB'(p0);
        row.frm.pulse[1] = PB'(p1);
        row.frm.pulse[2] = PB'(p2);
        row.frm.pulse[3] = PB'(p3);
        row.frm.now = t;
        row.frm.sw = sw;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_cfg(logic [IDX_W-1:0] idx, int data);
        row_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.idx = idx;
        row.data = DATA_W'(data);
        stim_rows.push_back(row);
    endfunction

    // Attaches a hand-computed result to the most recent frame.
    function automatic void add_result(int v0, int v1, int v2, int v3,
                                       logic valid, logic link);
        row_t row;
        row = stim_rows.pop_back();
        row.typed = 1'b1;
        row.res.vals[0] = PB'(v0);
        row.res.vals[1] = PB'(v1);
        row.res.vals[2] = PB'(v2);
        row.res.vals[3] = PB'(v3);
        row.res.valid = valid;
        row.res.link = link;
        stim_rows.push_back(row);
    endfunction

    // Result side: random stalls, with phases of steady acceptance.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Compare each accepted result with the oldest pending one.
    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        int      k;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.vals  = m_tdata[4*PB-1:0];
            got.valid = m_tuser[rcslf_pkg::USER_VALID];
            got.link  = m_tuser[rcslf_pkg::USER_LINK];
            if (pending_results.size() == 0)
            begin
                $error("result item arrived with no frame pending");
                err_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                for (k = 0; k < NUM_CH; k++)
                    if (got.vals[k] !== want.vals[k])
                    begin
                        $error("value_%0d: expected %0d, got %0d",
                               k, want.vals[k], got.vals[k]);
                        err_cnt++;
                    end
                if (got.valid !== want.valid)
                begin
                    $error("channels_valid: expected %0d, got %0d", want.valid, got.valid);
                    err_cnt++;
                end
                if (got.link !== want.link)
                begin
                    $error("link_up: expected %0d, got %0d", want.link, got.link);
                    err_cnt++;
                end
                results_checked++;
            end
        end
    end

    // Stimulus: directed list, then randomized phases.
    initial
    begin : stimulus
        frame_t        f;
        int            ph;
        int            i;
        int            ch;
        int            pv;
        int            loss [NUM_CH];
        logic [31:0]   t_ms;
        logic [15:0]   c_min, c_max, c_mid, c_fs, c_act, c_req, c_hold;

        // Model state after reset.
        min_p    = rcslf_pkg::MIN_PULSE_RST[PB-1:0];
        max_p    = rcslf_pkg::MAX_PULSE_RST[PB-1:0];
        mid_v    = rcslf_pkg::MID_VALUE_RST[PB-1:0];
        fs_en    = 1'b0;
        act_ch   = rcslf_pkg::ACTIVE_RST;
        req_mask = rcslf_pkg::REQUIRED_RST;
        hold_ms  = rcslf_pkg::HOLD_TIME_RST;
        for (ch = 0; ch < NUM_CH; ch++)
        begin
            held[ch] = (ch == THR_CH) ? min_p : mid_v;
            deadline[ch] = rcslf_pkg::DEADLINE_RST;
            for (i = 0; i < AVG; i++)
                history[ch][i] = '0;
        end
        slot = 0;
        hist_full = 1'b0;

        // Directed list. The first frames pass straight through the averager.
        add_frame(885, 2115, 1500, 1000, 32'd0, 1'b0);
        add_result(885, 2115, 1500, 1000, 1'b1, 1'b1);
        // Every pulse outside the window, deadlines not yet reached.
        add_frame(0, 4095, 884, 2116, 32'd10, 1'b0);
        add_result(885, 2115, 1500, 1000, 1'b1, 1'b1);
        // Switch alone does nothing while failsafe is disabled.
        add_frame(1000, 1000, 1000, 1000, 32'd20, 1'b1);
        add_result(1000, 1000, 1000, 1000, 1'b1, 1'b1);
        // Past every deadline: all channels fail and the link drops.
        add_frame(4095, 0, 4095, 0, 32'd400, 1'b0);
        add_result(1500, 1500, 1500, 885, 1'b0, 1'b0);
        add_cfg(rcslf_pkg::CFG_FS_ENABLED, 1);
        add_frame(1200, 1200, 1200, 1200, 32'd500, 1'b1);
        add_result(1500, 1500, 1500, 885, 1'b1, 1'b0);
        add_frame(1200, 1300, 1400, 1500, 32'd510, 1'b0);
        add_frame(2000, 900, 1100, 1900, 32'd520, 1'b0);
        // A failed channel outside the required set leaves the link up.
        add_cfg(rcslf_pkg::CFG_REQUIRED, 1);
        add_frame(1000, 1000, 1000, 4000, 32'd2000, 1'b0);
        // Channel count above four is clipped; zero processes nothing.
        add_cfg(rcslf_pkg::CFG_ACTIVE_CH, 7);
        add_frame(1111, 1222, 1333, 1444, 32'd2010, 1'b0);
        add_cfg(rcslf_pkg::CFG_ACTIVE_CH, 0);
        add_frame(0, 0, 0, 0, 32'd5000, 1'b0);
        add_cfg(rcslf_pkg::CFG_ACTIVE_CH, 2);
        add_frame(900, 3000, 0, 0, 32'd5010, 1'b0);
        // Zero hold time fails a bad pulse at once.
        add_cfg(rcslf_pkg::CFG_HOLD_TIME, 0);
        add_cfg(rcslf_pkg::CFG_REQUIRED, 15);
        add_frame(1000, 0, 1000, 1000, 32'd5020, 1'b0);
        // Deadline saturation near the top of the time range.
        add_cfg(rcslf_pkg::CFG_ACTIVE_CH, 4);
        add_cfg(rcslf_pkg::CFG_HOLD_TIME, 65535);
        add_frame(1000, 1000, 1000, 1000, 32'hFFFF_FFF0, 1'b0);
        add_frame(0, 0, 0, 0, 32'hFFFF_FFFE, 1'b0);
        add_frame(0, 0, 0, 0, 32'hFFFF_FFFF, 1'b0);
        // Inverted window rejects everything.
        add_cfg(rcslf_pkg::CFG_MIN_PULSE, 3000);
        add_cfg(rcslf_pkg::CFG_MAX_PULSE, 100);
        add_frame(100, 3000, 2000, 4095, 32'd10, 1'b0);
        // Widest window and extreme failsafe values.
        add_cfg(rcslf_pkg::CFG_MIN_PULSE, 0);
        add_cfg(rcslf_pkg::CFG_MAX_PULSE, 4095);
        add_cfg(rcslf_pkg::CFG_MID_VALUE, 4095);
        add_cfg(rcslf_pkg::CFG_HOLD_TIME, 300);
        add_frame(0, 4095, 0, 4095, 32'd20, 1'b0);
        add_frame(4095, 0, 4095, 0, 32'd30, 1'b1);
        add_cfg(rcslf_pkg::CFG_MID_VALUE, 0);
        add_frame(2048, 2047, 1, 4094, 32'd40, 1'b0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[r])
        begin
            if (stim_rows[r].kind == ROW_CFG)
                write_reg(stim_rows[r].idx, stim_rows[r].data);
            else
                send_frame(stim_rows[r].frm, stim_rows[r].typed, stim_rows[r].res);
        end

        // Random phases, each with its own register setting.
        for (ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0:
                begin
                    c_min = 885; c_max = 2115; c_mid = 1500; c_fs = 0;
                    c_act = 4; c_req = 15; c_hold = 300;
                end
                1:
                begin
                    c_min = 0; c_max = 4095; c_mid = 0; c_fs = 1;
                    c_act = 4; c_req = 15; c_hold = 1;
                end
                2:
                begin
                    c_min = 4095; c_max = 4095; c_mid = 4095; c_fs = 1;
                    c_act = 7; c_req = 0; c_hold = 65535;
                end
                3:
                begin
                    c_min = 2000; c_max = 1000; c_mid = 16'($urandom_range(0, 4095));
                    c_fs = 16'($urandom_range(0, 1)); c_act = 16'($urandom_range(0, 7));
                    c_req = 16'($urandom_range(0, 15)); c_hold = 16'($urandom_range(0, 600));
                end
                default:
                begin
                    c_min = 16'($urandom_range(600, 1200));
                    c_max = 16'($urandom_range(1700, 2400));
                    c_mid = 16'($urandom_range(0, 4095));
                    c_fs  = 16'($urandom_range(0, 1));
                    c_act = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7)) : 16'd4;
                    c_req = 16'($urandom_range(0, 15));
                    c_hold = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                         : 16'($urandom_range(0, 800));
                end
            endcase
            write_reg(rcslf_pkg::CFG_MIN_PULSE, c_min);
            write_reg(rcslf_pkg::CFG_MAX_PULSE, c_max);
            write_reg(rcslf_pkg::CFG_MID_VALUE, c_mid);
            write_reg(rcslf_pkg::CFG_FS_ENABLED, c_fs);
            write_reg(rcslf_pkg::CFG_ACTIVE_CH, c_act);
            write_reg(rcslf_pkg::CFG_REQUIRED, c_req);
            write_reg(rcslf_pkg::CFG_HOLD_TIME, c_hold);

            no_idle <= (ph % 4 == 1);
            case (ph % 3)
                0:       t_ms = $urandom();
                1:       t_ms = $urandom_range(0, 1000);
                default: t_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
            endcase
            for (ch = 0; ch < NUM_CH; ch++)
                loss[ch] = 0;

            for (i = 0; i < 155; i++)
            begin
                // Each channel drops out now and then for a burst of frames.
                for (ch = 0; ch < NUM_CH; ch++)
                begin
                    if (loss[ch] == 0 && $urandom_range(0, 24) == 0)
                        loss[ch] = $urandom_range(1, 40);
                    if ($urandom_range(0, 39) == 0)
                        pv = $urandom_range(0, 4095);
                    else if (loss[ch] > 0)
                    begin
                        loss[ch]--;
                        case ($urandom_range(0, 2))
                            0:       pv = (c_min > 0) ? $urandom_range(0, c_min - 1)
                                                      : $urandom_range(0, 4095);
                            1:       pv = (c_max < 4095) ? $urandom_range(c_max + 1, 4095)
                                                         : $urandom_range(0, 4095);
                            default: pv = $urandom_range(0, 4095);
                        endcase
                    end
                    else if (c_min <= c_max)
                        pv = $urandom_range(c_min, c_max);
                    else
                        pv = $urandom_range(0, 4095);
                    f.pulse[ch] = PB'(pv);
                end
                f.now = t_ms;
                f.sw = ($urandom_range(0, 15) == 0);
                send_frame(f, 1'b0, '0);

                // Mostly steady frame spacing, with occasional long gaps and jumps.
                if ($urandom_range(0, 49) == 0)
                    t_ms = $urandom();
                else if ($urandom_range(0, 9) == 0)
                    t_ms = t_ms + $urandom_range(0, 2000);
                else
                    t_ms = t_ms + $urandom_range(0, 40);
            end
        end

        // Drain and let the pipeline settle.
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d frames and %0d register writes; %0d results compared.",
                 frames_sent, cfg_writes, results_checked);
        $display("Link down on %0d frames; %0d channel holds and %0d failsafe substitutions.",
                 link_downs, hold_hits, fs_hits);
        if (err_cnt == 0)
            $display("rc_channel_signal_loss_filter test passed");
        else
            $display("rc_channel_signal_loss_filter test failed");
        $finish;
    end

endmodule
